// ===== design/angle_bias_kalman_filter_macros.svh =====
// ----------------------------------------------------------------------------
// angle bias kalman filter assertion macros
// shared concurrent assertion forms, removable with ASSERT_OFF
// ----------------------------------------------------------------------------
`ifndef ANGLE_BIAS_KALMAN_FILTER_MACROS_SVH
`define ANGLE_BIAS_KALMAN_FILTER_MACROS_SVH

`ifndef ASSERT_OFF
`define ABKF_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("abkf assertion failed");
`define ABKF_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("abkf assertion failed");
`else
`define ABKF_ASSERT(lbl, clk, rstn, prop)
`define ABKF_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ===== design/abkf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abkf package
// operation codes, command and status types, constants and saturation
// ----------------------------------------------------------------------------
package abkf_pkg;

    typedef enum logic [3:0] {
        OP_ANGLE_PRED,
        OP_P00,
        OP_P_CROSS,
        OP_GAIN_K0,
        OP_GAIN_K1,
        OP_ANGLE_CORR,
        OP_BIAS_CORR,
        OP_C00,
        OP_C01,
        OP_C10,
        OP_C11
    } op_t;

    typedef struct packed {
        logic load;
        logic mul;
        logic wb;
        logic div_start;
        logic commit;
        op_t  op;
    } dp_cmd_t;

    typedef struct packed {
        logic div_busy;
    } dp_sts_t;

    localparam logic [1:0] CFG_ANGLE_NOISE   = 2'd0;
    localparam logic [1:0] CFG_BIAS_NOISE    = 2'd1;
    localparam logic [1:0] CFG_MEASURE_NOISE = 2'd2;

    localparam logic [24:0] ANGLE_NOISE_RST   = 25'd16777;
    localparam logic [24:0] BIAS_NOISE_RST    = 25'd50332;
    localparam logic [27:0] MEASURE_NOISE_RST = 28'd8388608;

    localparam logic signed [31:0] ONE_Q24_S  = 32'sd16777216;
    localparam logic [24:0]        GAIN_ONE   = 25'd16777216;
    localparam logic signed [58:0] ROUND_HALF = 59'sd8388608;
    localparam logic [4:0]         DIV_STEPS  = 5'd24;

    function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
        logic signed [31:0] r;
        if (v > 38'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -38'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ===== design/abkf_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abkf datapath
// filter state, shared multiplier with rounding, bit-serial gain divider
// ----------------------------------------------------------------------------
module abkf_datapath (
    input  logic                aclk,
    input  logic                aresetn,
    input  abkf_pkg::dp_cmd_t   cmd,
    output abkf_pkg::dp_sts_t   sts,
    input  logic                cfg_wr_en,
    input  logic [1:0]          cfg_index,
    input  logic [27:0]         cfg_data,
    input  logic signed [24:0]  s_accel_angle,
    input  logic signed [27:0]  s_gyro_rate,
    input  logic [23:0]         s_time_step,
    output logic signed [31:0]  m_filtered_angle
);

    logic [24:0]        qa_reg, qg_reg;
    logic [27:0]        r_reg;
    logic signed [24:0] acc_reg;
    logic signed [27:0] gyro_reg;
    logic [23:0]        dt_reg;
    logic signed [31:0] angle_reg, bias_reg, c00_reg, c01_reg, c10_reg, c11_reg;
    logic signed [31:0] p00_reg, p01_reg, p10_reg, p11_reg;
    logic [24:0]        k0_reg, k1_reg;
    logic signed [32:0] innov_reg;
    logic signed [58:0] prod_reg;
    logic signed [31:0] out_reg;
    logic               div_act_reg, div_k1_reg;
    logic [4:0]         div_cnt_reg;
    logic [32:0]        rem_reg, den_reg;
    logic [23:0]        quo_reg;

    logic signed [32:0] mul_a, innov_now;
    logic signed [25:0] mul_b;
    logic signed [58:0] prod_next, prod_rnd;
    logic signed [37:0] rnd;
    logic signed [33:0] den_now;
    logic signed [31:0] num_now;
    logic [33:0]        rem2;
    logic               rem_ge;
    logic [32:0]        rem_next;
    logic [23:0]        quo_next;

    assign innov_now = 33'(acc_reg) - 33'(angle_reg);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.op)
            abkf_pkg::OP_ANGLE_PRED: begin
                mul_a = 33'(gyro_reg) - 33'(bias_reg);
                mul_b = $signed({2'b00, dt_reg});
            end
            abkf_pkg::OP_P00: begin
                mul_a = 33'(c01_reg) + 33'(c10_reg);
                mul_b = $signed({2'b00, dt_reg});
            end
            abkf_pkg::OP_P_CROSS: begin
                mul_a = 33'(c11_reg);
                mul_b = $signed({2'b00, dt_reg});
            end
            abkf_pkg::OP_ANGLE_CORR: begin
                mul_a = innov_now;
                mul_b = $signed({1'b0, k0_reg});
            end
            abkf_pkg::OP_BIAS_CORR: begin
                mul_a = innov_reg;
                mul_b = $signed({1'b0, k1_reg});
            end
            abkf_pkg::OP_C00: begin
                mul_a = 33'(p00_reg);
                mul_b = $signed({1'b0, k0_reg});
            end
            abkf_pkg::OP_C01: begin
                mul_a = 33'(p01_reg);
                mul_b = $signed({1'b0, k0_reg});
            end
            abkf_pkg::OP_C10: begin
                mul_a = 33'(p00_reg);
                mul_b = $signed({1'b0, k1_reg});
            end
            abkf_pkg::OP_C11: begin
                mul_a = 33'(p01_reg);
                mul_b = $signed({1'b0, k1_reg});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = 59'(mul_a) * 59'(mul_b);
    assign prod_rnd  = prod_reg + abkf_pkg::ROUND_HALF;
    assign rnd       = 38'($signed(prod_rnd[58:24]));

    // gain divider
    assign den_now  = 34'(p00_reg) + $signed({6'b0, r_reg});
    assign num_now  = (cmd.op == abkf_pkg::OP_GAIN_K1) ? p10_reg : p00_reg;
    assign rem2     = {rem_reg, 1'b0};
    assign rem_ge   = rem2 >= {1'b0, den_reg};
    assign rem_next = rem_ge ? 33'(rem2 - {1'b0, den_reg}) : rem2[32:0];
    assign quo_next = {quo_reg[22:0], rem_ge};

    assign sts.div_busy    = div_act_reg;
    assign m_filtered_angle = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            qa_reg      <= abkf_pkg::ANGLE_NOISE_RST;
            qg_reg      <= abkf_pkg::BIAS_NOISE_RST;
            r_reg       <= abkf_pkg::MEASURE_NOISE_RST;
            angle_reg   <= '0;
            bias_reg    <= '0;
            c00_reg     <= abkf_pkg::ONE_Q24_S;
            c01_reg     <= '0;
            c10_reg     <= '0;
            c11_reg     <= abkf_pkg::ONE_Q24_S;
            div_act_reg <= 1'b0;
            div_cnt_reg <= '0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    abkf_pkg::CFG_ANGLE_NOISE:   qa_reg <= cfg_data[24:0];
                    abkf_pkg::CFG_BIAS_NOISE:    qg_reg <= cfg_data[24:0];
                    abkf_pkg::CFG_MEASURE_NOISE: r_reg  <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.load) begin
                acc_reg  <= s_accel_angle;
                gyro_reg <= s_gyro_rate;
                dt_reg   <= s_time_step;
            end
            if (cmd.mul) begin
                prod_reg <= prod_next;
                if (cmd.op == abkf_pkg::OP_ANGLE_CORR) begin
                    innov_reg <= innov_now;
                end
            end
            if (cmd.wb) begin
                unique case (cmd.op)
                    abkf_pkg::OP_ANGLE_PRED, abkf_pkg::OP_ANGLE_CORR: begin
                        angle_reg <= abkf_pkg::sat32(38'(angle_reg) + rnd);
                    end
                    abkf_pkg::OP_P00: begin
                        p00_reg <= abkf_pkg::sat32(38'(c00_reg)
                                   + $signed({13'b0, qa_reg}) - rnd);
                    end
                    abkf_pkg::OP_P_CROSS: begin
                        p01_reg <= abkf_pkg::sat32(38'(c01_reg) - rnd);
                        p10_reg <= abkf_pkg::sat32(38'(c10_reg) - rnd);
                        p11_reg <= abkf_pkg::sat32(38'(c11_reg) + $signed({13'b0, qg_reg}));
                    end
                    abkf_pkg::OP_BIAS_CORR: bias_reg <= abkf_pkg::sat32(38'(bias_reg) + rnd);
                    abkf_pkg::OP_C00: c00_reg <= abkf_pkg::sat32(38'(p00_reg) - rnd);
                    abkf_pkg::OP_C01: c01_reg <= abkf_pkg::sat32(38'(p01_reg) - rnd);
                    abkf_pkg::OP_C10: c10_reg <= abkf_pkg::sat32(38'(p10_reg) - rnd);
                    abkf_pkg::OP_C11: c11_reg <= abkf_pkg::sat32(38'(p11_reg) - rnd);
                    default: ;
                endcase
            end
            if (cmd.div_start) begin
                div_k1_reg <= (cmd.op == abkf_pkg::OP_GAIN_K1);
                if (den_now <= 34'sd0 || num_now <= 32'sd0) begin
                    if (cmd.op == abkf_pkg::OP_GAIN_K1) k1_reg <= '0;
                    else k0_reg <= '0;
                end else if (34'(num_now) >= den_now) begin
                    if (cmd.op == abkf_pkg::OP_GAIN_K1) k1_reg <= abkf_pkg::GAIN_ONE;
                    else k0_reg <= abkf_pkg::GAIN_ONE;
                end else begin
                    div_act_reg <= 1'b1;
                    div_cnt_reg <= abkf_pkg::DIV_STEPS;
                    rem_reg     <= {1'b0, num_now};
                    den_reg     <= den_now[32:0];
                    quo_reg     <= '0;
                end
            end else if (div_act_reg) begin
                rem_reg     <= rem_next;
                quo_reg     <= quo_next;
                div_cnt_reg <= div_cnt_reg - 5'd1;
                if (div_cnt_reg == 5'd1) begin
                    div_act_reg <= 1'b0;
                    if (div_k1_reg) k1_reg <= {1'b0, quo_next};
                    else k0_reg <= {1'b0, quo_next};
                end
            end
            if (cmd.commit) begin
                out_reg <= angle_reg;
            end
        end
    end

endmodule

// ===== design/abkf_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abkf controller
// sequences the predict, gain and correct operations of one sample
// ----------------------------------------------------------------------------
module abkf_controller (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output abkf_pkg::dp_cmd_t cmd,
    input  abkf_pkg::dp_sts_t sts
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_WB,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_OUT
    } state_t;

    state_t          state_reg;
    abkf_pkg::op_t   op_reg;
    logic            m_valid_reg;
    abkf_pkg::op_t   op_succ;
    logic            succ_is_div;

    always_comb begin
        unique case (op_reg)
            abkf_pkg::OP_ANGLE_PRED: op_succ = abkf_pkg::OP_P00;
            abkf_pkg::OP_P00:        op_succ = abkf_pkg::OP_P_CROSS;
            abkf_pkg::OP_P_CROSS:    op_succ = abkf_pkg::OP_GAIN_K0;
            abkf_pkg::OP_GAIN_K0:    op_succ = abkf_pkg::OP_GAIN_K1;
            abkf_pkg::OP_GAIN_K1:    op_succ = abkf_pkg::OP_ANGLE_CORR;
            abkf_pkg::OP_ANGLE_CORR: op_succ = abkf_pkg::OP_BIAS_CORR;
            abkf_pkg::OP_BIAS_CORR:  op_succ = abkf_pkg::OP_C00;
            abkf_pkg::OP_C00:        op_succ = abkf_pkg::OP_C01;
            abkf_pkg::OP_C01:        op_succ = abkf_pkg::OP_C10;
            abkf_pkg::OP_C10:        op_succ = abkf_pkg::OP_C11;
            default:                 op_succ = abkf_pkg::OP_ANGLE_PRED;
        endcase
    end

    assign succ_is_div = (op_succ == abkf_pkg::OP_GAIN_K0)
                      || (op_succ == abkf_pkg::OP_GAIN_K1);

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

    always_comb begin
        cmd.op        = op_reg;
        cmd.load      = (state_reg == ST_IDLE) && s_valid;
        cmd.mul       = (state_reg == ST_MUL);
        cmd.wb        = (state_reg == ST_WB);
        cmd.div_start = (state_reg == ST_DIV_START);
        cmd.commit    = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            op_reg      <= abkf_pkg::OP_ANGLE_PRED;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.commit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        op_reg    <= abkf_pkg::OP_ANGLE_PRED;
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL: state_reg <= ST_WB;
                ST_WB, ST_DIV_WAIT: begin
                    if (!(state_reg == ST_DIV_WAIT && sts.div_busy)) begin
                        if (op_reg == abkf_pkg::OP_C11) begin
                            state_reg <= ST_OUT;
                        end else begin
                            op_reg    <= op_succ;
                            state_reg <= succ_is_div ? ST_DIV_START : ST_MUL;
                        end
                    end
                end
                ST_DIV_START: state_reg <= ST_DIV_WAIT;
                ST_OUT: begin
                    if (cmd.commit) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// ===== design/angle_bias_kalman_filter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// angle bias kalman filter
// two-state tilt filter fusing accelerometer angle and gyro rate
// ----------------------------------------------------------------------------
// One sample is in work at a time: nine multiplies run through one
// shared 33x26 multiplier, and two gains come from a bit-serial divider at
// one quotient bit per cycle for 24 bits, with the divider skipped when a
// gain is 0 or clamped to 1. The hand-over of the filtered angle waits while
// the output register still holds a result that has not been taken.
// The result sits in an output register, so the next sample is taken while it
// waits. A noise register write takes effect from the next operation that reads it, even within the sample in work.
`include "angle_bias_kalman_filter_macros.svh"

module angle_bias_kalman_filter (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_index,
    input  logic [27:0]        cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [24:0] s_accel_angle,
    input  logic signed [27:0] s_gyro_rate,
    input  logic [23:0]        s_time_step,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_filtered_angle
);

    abkf_pkg::dp_cmd_t cmd;
    abkf_pkg::dp_sts_t sts;

    abkf_controller u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    abkf_datapath u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .sts              (sts),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_accel_angle    (s_accel_angle),
        .s_gyro_rate      (s_gyro_rate),
        .s_time_step      (s_time_step),
        .m_filtered_angle (m_filtered_angle)
    );

    `ABKF_ASSERT(a_idle_not_dividing, aclk, aresetn, !(s_ready && sts.div_busy))
    `ABKF_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)
    `ABKF_ASSERT_NEXT(a_commit_shows_result, aclk, aresetn, cmd.commit, m_valid)

endmodule
